### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Width of every operand and result part.
  localparam int unsigned CAU_DW = 16;

  // Operation codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CAU_DW-1:0] a_re;
    logic signed [CAU_DW-1:0] a_im;
    logic signed [CAU_DW-1:0] b_re;
    logic signed [CAU_DW-1:0] b_im;
  } in_word_t;

  typedef struct packed {
    logic signed [CAU_DW-1:0] res_re;
    logic signed [CAU_DW-1:0] res_im;
    logic                     saturated;
    logic                     div_by_zero;
  } out_word_t;

  // Data that rides along the divider chain next to the quotient lanes.
  typedef struct packed {
    out_word_t pre;
    logic      is_div;
    logic      sign_re;
    logic      sign_im;
  } side_t;

endpackage

### rtl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step for the real and imaginary lanes, registered.
// ----------------------------------------------------------------------------
module cau_div_cell #(
  parameter int unsigned NW = 41,
  parameter int unsigned RW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  logic [NW-1:0]   num_re_i,
  input  logic [NW-1:0]   num_im_i,
  input  logic [RW-1:0]   rem_re_i,
  input  logic [RW-1:0]   rem_im_i,
  input  logic [NW-1:0]   q_re_i,
  input  logic [NW-1:0]   q_im_i,
  input  logic [RW-1:0]   den_i,
  input  cau_pkg::side_t  side_i,
  output logic            valid_o,
  output logic [NW-1:0]   num_re_o,
  output logic [NW-1:0]   num_im_o,
  output logic [RW-1:0]   rem_re_o,
  output logic [RW-1:0]   rem_im_o,
  output logic [NW-1:0]   q_re_o,
  output logic [NW-1:0]   q_im_o,
  output logic [RW-1:0]   den_o,
  output cau_pkg::side_t  side_o
);
  import cau_pkg::*;

  logic [RW:0]   t_re;
  logic [RW:0]   t_im;
  logic          ge_re;
  logic          ge_im;
  logic [RW:0]   d_re;
  logic [RW:0]   d_im;

  // Bring down the next numerator bit and try the subtraction.
  always_comb begin
    t_re  = {rem_re_i, num_re_i[NW-1]};
    t_im  = {rem_im_i, num_im_i[NW-1]};
    ge_re = t_re >= {1'b0, den_i};
    ge_im = t_im >= {1'b0, den_i};
    d_re  = ge_re ? (t_re - {1'b0, den_i}) : t_re;
    d_im  = ge_im ? (t_im - {1'b0, den_i}) : t_im;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      num_re_o <= {num_re_i[NW-2:0], 1'b0};
      num_im_o <= {num_im_i[NW-2:0], 1'b0};
      rem_re_o <= d_re[RW-1:0];
      rem_im_o <= d_im[RW-1:0];
      q_re_o   <= {q_re_i[NW-2:0], ge_re};
      q_im_o   <= {q_im_i[NW-2:0], ge_im};
      den_o    <= den_i;
      side_o   <= side_i;
    end
  end

endmodule

### rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_word) carries an opcode and two
//   complex operands. The result channel (out_valid, out_stall, out_word)
//   returns one word per input word, in order, with saturation and
//   divide-by-zero flags.
//   Every operation goes through the same pipeline: an input register, a
//   multiplier stage, a sum stage, a chain of 2*16+1+FRAC_BITS division
//   cells (one quotient bit per cell, both parts in parallel) and the output
//   register. One word is accepted every cycle while in_stall is low.
//   A skid register behind the pipeline takes one word when the receiver
//   stalls; in_stall rises only while that register is full.
//   Reset clears all valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cau_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cau_pkg::out_word_t  out_word
);
  import cau_pkg::*;

  localparam int unsigned DW = CAU_DW;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned MW = PW + 1;
  localparam int unsigned NW = MW + FRAC_BITS;
  localparam int unsigned RW = PW;

  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
  localparam logic [NW-1:0] QMAX_POS = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [NW-1:0] QMAX_NEG = {{(NW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  // Clamp a wide signed value to the part range.
  function automatic logic [DW:0] clamp_mw(input logic signed [MW-1:0] v);
    logic [DW:0] r;
    if (v > $signed({{(MW-DW){1'b0}}, MAX_V[DW-2:0]} | {(MW){1'b0}})) begin
      r = {MAX_V, 1'b1};
    end else if (v < $signed({{(MW-DW+1){1'b1}}, {(DW-1){1'b0}}})) begin
      r = {MIN_V, 1'b1};
    end else begin
      r = {v[DW-1:0], 1'b0};
    end
    return r;
  endfunction

  logic       en;
  logic       skid_full_r;
  out_word_t  skid_r;
  logic       out_valid_r;
  out_word_t  out_word_r;

  assign en        = !skid_full_r;
  assign in_stall  = skid_full_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Input register.
  logic      s0_v_r;
  in_word_t  s0_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_w_r <= in_word;
    end
  end

  // Multiplier stage: cross products, squares, plain sums and differences.
  logic                 s1_v_r;
  logic [1:0]           s1_op_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, sq_r_r, sq_i_r;
  logic signed [DW:0]   add_re_r, add_im_r, sub_re_r, sub_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r  <= s0_w_r.op;
      p_rr_r   <= s0_w_r.a_re * s0_w_r.b_re;
      p_ii_r   <= s0_w_r.a_im * s0_w_r.b_im;
      p_ir_r   <= s0_w_r.a_im * s0_w_r.b_re;
      p_ri_r   <= s0_w_r.a_re * s0_w_r.b_im;
      sq_r_r   <= s0_w_r.b_re * s0_w_r.b_re;
      sq_i_r   <= s0_w_r.b_im * s0_w_r.b_im;
      add_re_r <= {s0_w_r.a_re[DW-1], s0_w_r.a_re} + {s0_w_r.b_re[DW-1], s0_w_r.b_re};
      add_im_r <= {s0_w_r.a_im[DW-1], s0_w_r.a_im} + {s0_w_r.b_im[DW-1], s0_w_r.b_im};
      sub_re_r <= {s0_w_r.a_re[DW-1], s0_w_r.a_re} - {s0_w_r.b_re[DW-1], s0_w_r.b_re};
      sub_im_r <= {s0_w_r.a_im[DW-1], s0_w_r.a_im} - {s0_w_r.b_im[DW-1], s0_w_r.b_im};
    end
  end

  // Sum stage: combine products, finish the non-divide results, prepare the
  // numerator magnitudes for the division chain.
  logic signed [MW-1:0] m_re, m_im, n_re, n_im, ms_re, ms_im, sel_re, sel_im;
  logic [MW-1:0]        mag_re, mag_im;
  logic [RW-1:0]        den;
  logic [DW:0]          cl_re, cl_im;
  side_t                side_nxt;

  always_comb begin
    m_re  = {p_rr_r[PW-1], p_rr_r} - {p_ii_r[PW-1], p_ii_r};
    m_im  = {p_ir_r[PW-1], p_ir_r} + {p_ri_r[PW-1], p_ri_r};
    n_re  = {p_rr_r[PW-1], p_rr_r} + {p_ii_r[PW-1], p_ii_r};
    n_im  = {p_ir_r[PW-1], p_ir_r} - {p_ri_r[PW-1], p_ri_r};
    ms_re = m_re >>> FRAC_BITS;
    ms_im = m_im >>> FRAC_BITS;
    den   = $unsigned(sq_r_r) + $unsigned(sq_i_r);
    mag_re = n_re[MW-1] ? $unsigned(-n_re) : $unsigned(n_re);
    mag_im = n_im[MW-1] ? $unsigned(-n_im) : $unsigned(n_im);
    case (s1_op_r)
      OP_ADD: begin
        sel_re = MW'(add_re_r);
        sel_im = MW'(add_im_r);
      end
      OP_SUB: begin
        sel_re = MW'(sub_re_r);
        sel_im = MW'(sub_im_r);
      end
      OP_MUL: begin
        sel_re = ms_re;
        sel_im = ms_im;
      end
      default: begin
        sel_re = '0;
        sel_im = '0;
      end
    endcase
    cl_re = clamp_mw(sel_re);
    cl_im = clamp_mw(sel_im);
    side_nxt.pre.res_re      = cl_re[DW:1];
    side_nxt.pre.res_im      = cl_im[DW:1];
    side_nxt.pre.saturated   = cl_re[0] | cl_im[0];
    side_nxt.pre.div_by_zero = (s1_op_r == OP_DIV) && (den == '0);
    side_nxt.is_div          = (s1_op_r == OP_DIV) && (den != '0);
    side_nxt.sign_re         = n_re[MW-1];
    side_nxt.sign_im         = n_im[MW-1];
  end

  // Division chain.
  logic          c_v      [NW+1];
  logic [NW-1:0] c_num_re [NW+1];
  logic [NW-1:0] c_num_im [NW+1];
  logic [RW-1:0] c_rem_re [NW+1];
  logic [RW-1:0] c_rem_im [NW+1];
  logic [NW-1:0] c_q_re   [NW+1];
  logic [NW-1:0] c_q_im   [NW+1];
  logic [RW-1:0] c_den    [NW+1];
  side_t         c_side   [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v[0] <= 1'b0;
    end else if (en) begin
      c_v[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num_re[0] <= {mag_re, {FRAC_BITS{1'b0}}};
      c_num_im[0] <= {mag_im, {FRAC_BITS{1'b0}}};
      c_rem_re[0] <= '0;
      c_rem_im[0] <= '0;
      c_q_re[0]   <= '0;
      c_q_im[0]   <= '0;
      c_den[0]    <= den;
      c_side[0]   <= side_nxt;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_cell
    cau_div_cell #(.NW(NW), .RW(RW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_i  (c_v[i]),
      .num_re_i (c_num_re[i]),
      .num_im_i (c_num_im[i]),
      .rem_re_i (c_rem_re[i]),
      .rem_im_i (c_rem_im[i]),
      .q_re_i   (c_q_re[i]),
      .q_im_i   (c_q_im[i]),
      .den_i    (c_den[i]),
      .side_i   (c_side[i]),
      .valid_o  (c_v[i+1]),
      .num_re_o (c_num_re[i+1]),
      .num_im_o (c_num_im[i+1]),
      .rem_re_o (c_rem_re[i+1]),
      .rem_im_o (c_rem_im[i+1]),
      .q_re_o   (c_q_re[i+1]),
      .q_im_o   (c_q_im[i+1]),
      .den_o    (c_den[i+1]),
      .side_o   (c_side[i+1])
    );
  end

  // Apply quotient signs and clamp.
  logic          fin_v;
  out_word_t     fin_w;
  logic [NW-1:0] q_re, q_im;
  logic          sat_re, sat_im;
  logic [DW-1:0] v_re, v_im;

  always_comb begin
    q_re   = c_q_re[NW];
    q_im   = c_q_im[NW];
    sat_re = c_side[NW].sign_re ? (q_re > QMAX_NEG) : (q_re > QMAX_POS);
    sat_im = c_side[NW].sign_im ? (q_im > QMAX_NEG) : (q_im > QMAX_POS);
    v_re   = c_side[NW].sign_re ? (sat_re ? MIN_V : -q_re[DW-1:0])
                                : (sat_re ? MAX_V : q_re[DW-1:0]);
    v_im   = c_side[NW].sign_im ? (sat_im ? MIN_V : -q_im[DW-1:0])
                                : (sat_im ? MAX_V : q_im[DW-1:0]);
    fin_v  = c_v[NW];
    if (c_side[NW].is_div) begin
      fin_w.res_re      = v_re;
      fin_w.res_im      = v_im;
      fin_w.saturated   = sat_re | sat_im;
      fin_w.div_by_zero = 1'b0;
    end else begin
      fin_w = c_side[NW].pre;
    end
  end

  // Output register with skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= skid_full_r | fin_v;
      skid_full_r <= 1'b0;
    end else if (en && fin_v) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_word_r <= skid_full_r ? skid_r : fin_w;
    end else if (en && fin_v) begin
      skid_r <= fin_w;
    end
  end

endmodule

### rtl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level assertions for the complex arithmetic unit.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cau_pkg::in_word_t   in_word,
  input logic                out_valid,
  input logic                out_stall,
  input cau_pkg::out_word_t  out_word
);
  import cau_pkg::*;

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("out word dropped");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word)) else $error("out word changed");

  // The input side backs up only behind a waiting result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("in_stall without pending word");

  // A zero divisor gives zero parts and no saturation.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.div_by_zero |->
      out_word.res_re == '0 && out_word.res_im == '0 && !out_word.saturated)
    else $error("divide by zero word not cleared");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);

### test/complex_arithmetic_unit_core_tb.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core_tb
// Drives opcodes and complex operands into the unit and checks every result
// word against a local model of the fixed-point arithmetic and its flags.
// A short table of directed words comes first, then random words under
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cau_pkg::*;

  localparam int FRAC = 8;
  localparam int N_RANDOM = 1030;
  localparam int LATENCY = FRAC + 37;
  localparam int STUCK_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  out_word_t expected_words[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_sat = 0;
  int n_dz = 0;
  int stuck_cycles = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  complex_arithmetic_unit_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor shift of a product sum by the fraction width.
  function automatic longint floor_frac(input longint v);
    floor_frac = v >>> FRAC;
  endfunction

  // Clamp one part to the 16-bit range.
  function automatic logic signed [15:0] clamp16(input longint v, inout logic flag);
    if (v > 32767) begin
      flag = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      flag = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Complex arithmetic result for one input word.
  function automatic out_word_t complex_result(input in_word_t w);
    longint ar, ai, br, bi, re, im, den;
    logic sat;
    out_word_t r;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    re = 0; im = 0; sat = 1'b0;
    r = '0;
    case (w.op)
      OP_ADD: begin
        re = ar + br; im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br; im = ai - bi;
      end
      OP_MUL: begin
        re = floor_frac(ar * br - ai * bi);
        im = floor_frac(ai * br + ar * bi);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) r.div_by_zero = 1'b1;
        else begin
          // SystemVerilog division truncates toward zero.
          re = ((ar * br + ai * bi) * (64'sd1 << FRAC)) / den;
          im = ((ai * br - ar * bi) * (64'sd1 << FRAC)) / den;
        end
      end
    endcase
    r.res_re = clamp16(re, sat);
    r.res_im = clamp16(im, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int k;
    w.op = 2'($urandom_range(0, 3));
    w.a_re = 16'($urandom); w.a_im = 16'($urandom);
    w.b_re = 16'($urandom); w.b_im = 16'($urandom);
    k = $urandom_range(0, 9);
    // Small operands keep products and quotients mostly in range.
    if (k < 4) begin
      w.a_re = 16'(int'($urandom_range(0, 2047)) - 1024);
      w.a_im = 16'(int'($urandom_range(0, 2047)) - 1024);
      w.b_re = 16'(int'($urandom_range(0, 2047)) - 1024);
      w.b_im = 16'(int'($urandom_range(0, 2047)) - 1024);
    end else if (k == 4 && w.op == OP_DIV) begin
      w.b_re = '0; w.b_im = '0;
    end
    return w;
  endfunction

  // Directed word table; a set typed flag means the typed expectation is used.
  typedef struct {
    in_word_t word;
    bit typed;
    out_word_t result;
  } vector_t;

  vector_t vectors[$];

  task automatic add_vec(input logic [1:0] op, input int ar, ai, br, bi,
                         input bit typed = 0, input int rr = 0, ri = 0,
                         input bit sat = 0, input bit dz = 0);
    vector_t v;
    v.word = '{op, 16'(ar), 16'(ai), 16'(br), 16'(bi)};
    v.typed = typed;
    v.result = '{16'(rr), 16'(ri), sat, dz};
    vectors.push_back(v);
  endtask

  task automatic send_word(input in_word_t w, input out_word_t exp_w);
    in_valid <= 1'b1;
    in_word <= w;
    expected_words.push_back(exp_w);
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Stimulus.
  initial begin
    in_word_t w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_vec(OP_ADD, 0, 0, 0, 0, 1, 0, 0);
    add_vec(OP_ADD, 32767, -32768, 32767, -32768, 1, 32767, -32768, 1);
    add_vec(OP_ADD, 32767, -32768, -32768, 32767, 1, -1, -1);
    add_vec(OP_SUB, -32768, 32767, 32767, -32768, 1, -32768, 32767, 1);
    add_vec(OP_SUB, 32767, 32767, 32767, 32767, 1, 0, 0);
    add_vec(OP_MUL, 256, 0, 256, 0, 1, 256, 0);
    add_vec(OP_MUL, 0, 256, 0, 256, 1, -256, 0);
    add_vec(OP_MUL, 32767, 32767, 32767, 32767);
    add_vec(OP_MUL, -32768, -32768, -32768, -32768);
    add_vec(OP_MUL, -1, 0, 1, 0, 1, -1, 0);
    add_vec(OP_MUL, -300, 511, 129, -77);
    add_vec(OP_DIV, 1234, -567, 0, 0, 1, 0, 0, 0, 1);
    add_vec(OP_DIV, -32768, 32767, 0, 0, 1, 0, 0, 0, 1);
    add_vec(OP_DIV, 512, 256, 256, 0, 1, 512, 256);
    add_vec(OP_DIV, 32767, 0, 1, 0, 1, 32767, 0, 1);
    add_vec(OP_DIV, -32768, 0, 1, 0, 1, -32768, 0, 1);
    add_vec(OP_DIV, -1, 1, 3, 0);
    add_vec(OP_DIV, 32767, -32768, -32768, 32767);
    add_vec(OP_DIV, 100, 200, -32768, -32768);
    add_vec(OP_DIV, -700, 33, 5, -9);

    foreach (vectors[i]) begin
      send_word(vectors[i].word,
                vectors[i].typed ? vectors[i].result : complex_result(vectors[i].word));
      sender_gap();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) calm = 1'b1;
      w = random_word();
      send_word(w, complex_result(w));
      sender_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the pipe.
  initial begin
    int held;
    held = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (held == 0 && n_sent > 300) begin
        out_stall <= 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        held = 1;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checking.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_seen++;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: %h", out_word);
        n_errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.saturated) n_sat++;
        if (out_word.div_by_zero) n_dz++;
        if (out_word.res_re !== e.res_re) begin
          $error("res_re expected %0d actual %0d", e.res_re, out_word.res_re);
          n_errors++;
        end
        if (out_word.res_im !== e.res_im) begin
          $error("res_im expected %0d actual %0d", e.res_im, out_word.res_im);
          n_errors++;
        end
        if (out_word.saturated !== e.saturated) begin
          $error("saturated expected %0b actual %0b", e.saturated, out_word.saturated);
          n_errors++;
        end
        if (out_word.div_by_zero !== e.div_by_zero) begin
          $error("div_by_zero expected %0b actual %0b", e.div_by_zero,
                 out_word.div_by_zero);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (expected_words.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d words, checked %0d results; %0d saturated, %0d divide-by-zero.",
             n_sent, n_seen, n_sat, n_dz);
    if (n_errors == 0 && expected_words.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
